@@ src/sync_length_crc_deframer_top_macros.svh @@
// Assertion macros shared by the deframer RTL
`ifndef SYNC_LENGTH_CRC_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_CRC_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define SLCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define SLCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ src/slcd_pkg.sv @@
package slcd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;
    localparam int IDX_W     = 5;
    localparam int MAX_BURST = 31;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT  = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_POLY_RST  = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT_RST  = 16'hFFFF;

    // queue sizes (powers of two)
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_RECV,
        MODE_SWALLOW
    } t_mode;

    typedef enum logic [1:0] {
        ST_BYTE     = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_OVERRUN  = 2'd3
    } t_status;

    // front to back: one command per finished frame or error
    typedef struct packed {
        t_status          kind;
        logic [IDX_W-1:0] len;
        logic             bank;
    } t_cmd;

    // back to front: a bank has been fully read
    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] frame_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              last;
    } t_result;

endpackage

@@ src/slcd_fifo.sv @@
module slcd_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PW'(1);
            if (do_pop)  r_rp <= r_rp + PW'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

@@ src/slcd_frame_ram.sv @@
module slcd_frame_ram #(
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);
    logic [7:0] r_mem [2**ADDR_W];
    logic [7:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

endmodule

@@ src/slcd_rx_front.sv @@
`include "sync_length_crc_deframer_top_macros.svh"

module slcd_rx_front #(
    parameter int BUFFER_DEPTH = 32,
    localparam int BANK_AW = $clog2(BUFFER_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]   i_rx_byte,
    // settings
    input  logic [slcd_pkg::BYTE_W-1:0]   i_sync_byte,
    input  logic [slcd_pkg::CRC_W-1:0]    i_crc_poly,
    input  logic [slcd_pkg::CRC_W-1:0]    i_crc_init,
    // frame store write port
    output logic                          o_wr_en,
    output logic [BANK_AW:0]              o_wr_addr,
    output logic [slcd_pkg::BYTE_W-1:0]   o_wr_data,
    // command queue
    output logic                          o_cmd_push,
    output slcd_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_full,
    input  slcd_pkg::t_done               i_done
);
    import slcd_pkg::*;

    localparam int MAX_LEN = (BUFFER_DEPTH - 2 < MAX_BURST - 1) ?
                             (BUFFER_DEPTH - 2) : (MAX_BURST - 1);

    t_mode              r_mode, n_mode;
    logic [IDX_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_len, n_len;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [BYTE_W-1:0]  r_crc_lo, n_crc_lo;
    logic               r_bank, n_bank;
    logic [1:0]         r_busy;

    logic               fire, is_sync, is_len, is_end, len_bad, crc_ok;
    logic [CRC_W-1:0]   crc_next;

    // reflected CRC over one byte, bit at a time
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    // stall while the bank to be written still drains, or no command space
    assign o_ready  = ~i_cmd_full & ~r_busy[r_bank];
    assign fire     = i_valid & o_ready;
    assign is_sync  = (i_rx_byte == i_sync_byte);
    assign is_len   = (r_count == IDX_W'(1));
    assign is_end   = (r_count == r_len + IDX_W'(1));
    assign len_bad  = (i_rx_byte < 8'd2) || (i_rx_byte > BYTE_W'(MAX_LEN));
    assign crc_ok   = (r_crc_lo == r_crc[7:0]) && (i_rx_byte == r_crc[15:8]);
    assign crc_next = crc_step(r_crc, i_rx_byte, i_crc_poly);

    // next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_HUNT: begin
                if (fire && is_sync) n_mode = MODE_RECV;
            end
            MODE_RECV: begin
                if (fire) begin
                    if (is_len) begin
                        if (len_bad) n_mode = MODE_HUNT;
                    end else if (is_end) begin
                        n_mode = crc_ok ? MODE_HUNT : MODE_SWALLOW;
                    end
                end
            end
            MODE_SWALLOW: begin
                if (fire) n_mode = MODE_HUNT;
            end
            default: n_mode = MODE_HUNT;
        endcase
    end

    // datapath, store writes and commands
    always_comb begin
        n_count    = r_count;
        n_len      = r_len;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_bank     = r_bank;
        o_wr_en    = 1'b0;
        o_wr_addr  = {r_bank, BANK_AW'(r_count)};
        o_wr_data  = i_rx_byte;
        o_cmd_push = 1'b0;
        o_cmd      = '{kind: ST_BYTE, len: r_len, bank: r_bank};
        case (r_mode)
            MODE_HUNT: begin
                o_wr_addr = {r_bank, BANK_AW'(0)};
                if (fire && is_sync) begin
                    o_wr_en = 1'b1;
                    n_count = IDX_W'(1);
                    n_crc   = i_crc_init;
                end
            end
            MODE_RECV: begin
                if (fire) begin
                    if (is_len) begin
                        if (len_bad) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = ST_LEN_ERR;
                            n_count    = '0;
                        end else begin
                            o_wr_en = 1'b1;
                            n_len   = IDX_W'(i_rx_byte);
                            n_crc   = crc_next;
                            n_count = IDX_W'(2);
                        end
                    end else begin
                        o_wr_en = 1'b1;
                        if (r_count < r_len)  n_crc    = crc_next;
                        if (r_count == r_len) n_crc_lo = i_rx_byte;
                        if (is_end) begin
                            o_cmd_push = 1'b1;
                            n_count    = '0;
                            if (crc_ok) n_bank = ~r_bank;
                            else        o_cmd.kind = ST_CRC_ERR;
                        end else begin
                            n_count = r_count + IDX_W'(1);
                        end
                    end
                end
            end
            MODE_SWALLOW: begin
                if (fire) begin
                    o_cmd_push = 1'b1;
                    o_cmd.kind = ST_OVERRUN;
                    n_count    = '0;
                end
            end
            default: n_count = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_count <= '0;
            r_len   <= '0;
            r_crc   <= CRC_INIT_RST;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_bank  <= n_bank;
            // bank busy from burst command until the back has read it out
            for (int i = 0; i < 2; i++) begin
                r_busy[i] <= (r_busy[i] & ~(i_done.valid & (i_done.bank == 1'(i))))
                           | (o_cmd_push & (o_cmd.kind == ST_BYTE) & (r_bank == 1'(i)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc_lo <= n_crc_lo;
    end

    `SLCD_ASSERT_NEVER(a_cmd_overflow, i_clk, i_rst_n, o_cmd_push && i_cmd_full, "command pushed into full queue")
    `SLCD_ASSERT_NEVER(a_busy_write, i_clk, i_rst_n, o_wr_en && r_busy[r_bank], "write into bank being drained")
    `SLCD_ASSERT_NEXT(a_bank_flip, i_clk, i_rst_n, o_cmd_push && (o_cmd.kind == ST_BYTE), r_bank != $past(r_bank), "bank did not switch after good frame")

endmodule

@@ src/slcd_burst_back.sv @@
`include "sync_length_crc_deframer_top_macros.svh"

module slcd_burst_back #(
    parameter int BUFFER_DEPTH = 32,
    localparam int BANK_AW = $clog2(BUFFER_DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command queue
    input  slcd_pkg::t_cmd                  i_cmd,
    input  logic                            i_cmd_empty,
    output logic                            o_cmd_pop,
    // frame store read port
    output logic                            o_rd_en,
    output logic [BANK_AW:0]                o_rd_addr,
    input  logic [slcd_pkg::BYTE_W-1:0]     i_rd_data,
    // result queue
    input  logic [slcd_pkg::OUT_CNT_W-1:0]  i_out_count,
    output logic                            o_out_push,
    output slcd_pkg::t_result               o_out_data,
    output slcd_pkg::t_done                 o_done
);
    import slcd_pkg::*;

    localparam int SW = OUT_CNT_W + 1;

    logic              r_active;
    logic              r_bank;
    logic [IDX_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_idx;

    // stage aligned with the registered store read
    logic              r_stg_valid;
    t_status           r_stg_status;
    logic [IDX_W-1:0]  r_stg_idx;
    logic              r_stg_last;

    logic              room, start, issue, iss_last;
    t_status           iss_status;
    logic [IDX_W-1:0]  iss_idx;
    logic              iss_bank;

    // room counts the word already in the stage
    assign room  = (SW'(i_out_count) + SW'(r_stg_valid)) < SW'(OUT_DEPTH);
    assign start = ~r_active & ~i_cmd_empty & room;
    assign issue = (r_active & room) | start;
    assign o_cmd_pop = start;

    // pick the word issued this cycle
    always_comb begin
        iss_status = ST_BYTE;
        iss_idx    = r_idx;
        iss_bank   = r_bank;
        iss_last   = (r_idx == r_len);
        if (!r_active) begin
            iss_status = i_cmd.kind;
            iss_idx    = '0;
            iss_bank   = i_cmd.bank;
            iss_last   = (i_cmd.kind != ST_BYTE);
        end
    end

    assign o_rd_en    = issue & (iss_status == ST_BYTE);
    assign o_rd_addr  = {iss_bank, BANK_AW'(iss_idx)};
    assign o_done     = '{valid: r_active & room & iss_last, bank: r_bank};

    // burst sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_stg_valid <= 1'b0;
        end else begin
            r_stg_valid <= issue;
            if (start && (i_cmd.kind == ST_BYTE)) begin
                r_active <= 1'b1;
            end else if (r_active && room && iss_last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_bank <= i_cmd.bank;
            r_len  <= i_cmd.len;
            r_idx  <= IDX_W'(1);
        end else if (r_active && room) begin
            r_idx  <= r_idx + IDX_W'(1);
        end
        if (issue) begin
            r_stg_status <= iss_status;
            r_stg_idx    <= iss_idx;
            r_stg_last   <= iss_last;
        end
    end

    // result word
    assign o_out_push = r_stg_valid;
    always_comb begin
        o_out_data.status     = r_stg_status;
        o_out_data.frame_byte = (r_stg_status == ST_BYTE) ? i_rd_data : '0;
        o_out_data.byte_index = (r_stg_status == ST_BYTE) ? r_stg_idx : '0;
        o_out_data.last       = r_stg_last;
    end

    `SLCD_ASSERT_IMP(a_out_room, i_clk, i_rst_n, r_stg_valid, i_out_count < OUT_CNT_W'(OUT_DEPTH), "result pushed into full queue")
    `SLCD_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_active, r_idx <= r_len, "burst index past frame length")
    `SLCD_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done.valid, !r_active && r_stg_last, "burst end not followed by idle")

endmodule

@@ src/sync_length_crc_deframer_top.sv @@
// Channel   | Ports                                          | Direction
// ----------+------------------------------------------------+-----------
// rx bytes  | push, full, i_rx_byte                          | in
// results   | empty, pop, o_status, o_frame_byte,            | out
//           | o_byte_index, o_last                           |
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// One byte is taken per cycle; the receive front updates its CRC and the frame
// store in that cycle. A good frame of length L drains as L+1 words, one per
// cycle while results have room, from the filled bank as the front fills the
// other. The front stalls (full) when the bank it would fill is still draining
// or the command queue is full. Synchronous active-low reset, no clearing pass.
module sync_length_crc_deframer_top #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // rx bytes
    input  logic                             push,
    output logic                             full,
    input  logic [slcd_pkg::BYTE_W-1:0]      i_rx_byte,
    // results
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       o_status,
    output logic [slcd_pkg::BYTE_W-1:0]      o_frame_byte,
    output logic [slcd_pkg::IDX_W-1:0]       o_byte_index,
    output logic                             o_last,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slcd_pkg::CRC_W-1:0]       i_cfg_data
);
    import slcd_pkg::*;

    localparam int BANK_AW = $clog2(BUFFER_DEPTH);

    logic [BYTE_W-1:0]   r_sync_byte;
    logic [CRC_W-1:0]    r_crc_poly;
    logic [CRC_W-1:0]    r_crc_init;

    logic                rdy;
    logic                wr_en, rd_en;
    logic [BANK_AW:0]    wr_addr, rd_addr;
    logic [BYTE_W-1:0]   wr_data, rd_data;
    logic                cmd_push, cmd_pop, cmd_full, cmd_empty;
    t_cmd                cmd_in, cmd_out;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    t_done               done;
    logic                out_push, out_full;
    t_result             out_in, out_head;
    logic [OUT_CNT_W-1:0] out_count;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= SYNC_BYTE_RST;
            r_crc_poly  <= CRC_POLY_RST;
            r_crc_init  <= CRC_INIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_BYTE: r_sync_byte <= i_cfg_data[BYTE_W-1:0];
                CFG_CRC_POLY:  r_crc_poly  <= i_cfg_data;
                CFG_CRC_INIT:  r_crc_init  <= i_cfg_data;
                default:       r_sync_byte <= r_sync_byte;
            endcase
        end
    end

    assign full = ~rdy;

    slcd_rx_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (push),
        .o_ready     (rdy),
        .i_rx_byte   (i_rx_byte),
        .i_sync_byte (r_sync_byte),
        .i_crc_poly  (r_crc_poly),
        .i_crc_init  (r_crc_init),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full),
        .i_done      (done)
    );

    slcd_frame_ram #(.ADDR_W(BANK_AW + 1)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    slcd_fifo #(.DEPTH(CMD_DEPTH), .WIDTH($bits(t_cmd))) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_full  (cmd_full),
        .o_count (cmd_count)
    );

    slcd_burst_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_in),
        .o_done      (done)
    );

    slcd_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(t_result))) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_empty (empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    // result word on the ports; the full flag only feeds a sanity gate
    assign o_status     = out_head.status;
    assign o_frame_byte = out_head.frame_byte;
    assign o_byte_index = out_head.byte_index;
    assign o_last       = out_head.last & ~(out_full & (cmd_count > CMD_DEPTH[1:0]));

endmodule

@@ sim/tb_sync_length_crc_deframer_top.sv @@
`timescale 1ns / 100ps

module tb_sync_length_crc_deframer_top;
    import slcd_pkg::*;

    localparam int BUFFER_DEPTH = 32;
    localparam int DRAIN_CYCLES = 40;      // settle time once nothing is expected
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 4;       // random frame bytes per phase
    localparam int NUM_PHASES   = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Running copy of the deframer: predicts output words, checks them in order
    class frame_checker;
        t_result           expected_words[$];
        int                mismatch_count;
        logic [BYTE_W-1:0] sync_val;
        logic [CRC_W-1:0]  poly_val;
        logic [CRC_W-1:0]  init_val;
        t_mode             mode;
        int                byte_count;
        int                frame_len;
        logic [BYTE_W-1:0] store [BUFFER_DEPTH];
        logic [CRC_W-1:0]  crc;

        function new();
            sync_val       = SYNC_BYTE_RST;
            poly_val       = CRC_POLY_RST;
            init_val       = CRC_INIT_RST;
            mode           = MODE_HUNT;
            byte_count     = 0;
            frame_len      = 0;
            crc            = CRC_INIT_RST;
            mismatch_count = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CRC_W-1:0] data);
            case (idx)
                CFG_SYNC_BYTE: sync_val = data[BYTE_W-1:0];
                CFG_CRC_POLY:  poly_val = data;
                CFG_CRC_INIT:  init_val = data;
                default: ;
            endcase
        endfunction

        // reflected CRC-16, one byte, LSB first
        function logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] r;
            int               k;
            r = c ^ {8'h00, b};
            for (k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ poly_val) : (r >> 1);
            return r;
        endfunction

        function void add_word(t_status st, logic [BYTE_W-1:0] fb, int ix, logic lst);
            t_result w;
            w.status     = st;
            w.frame_byte = fb;
            w.byte_index = ix[IDX_W-1:0];
            w.last       = lst;
            expected_words.push_back(w);
        endfunction

        // single status word, back to hunting
        function void end_with(t_status st);
            add_word(st, '0, 0, 1'b1);
            mode       = MODE_HUNT;
            byte_count = 0;
        endfunction

        function void take_rx_byte(logic [BYTE_W-1:0] b);
            int idx;
            int bv;
            int i;
            bit crc_ok;
            bv = int'(b);
            if (mode == MODE_SWALLOW) begin
                end_with(ST_OVERRUN);
                return;
            end
            if (mode != MODE_RECV) begin
                mode = MODE_HUNT;
                if (b == sync_val) begin
                    store[0]   = b;
                    byte_count = 1;
                    crc        = init_val;
                    mode       = MODE_RECV;
                end
                return;
            end
            idx = byte_count;
            // length byte
            if (idx <= 1) begin
                frame_len = bv;
                if (bv < 2 || bv + 2 > BUFFER_DEPTH || bv + 1 > MAX_BURST) begin
                    end_with(ST_LEN_ERR);
                    return;
                end
                store[1]   = b;
                crc        = crc_byte(crc, b);
                byte_count = 2;
                return;
            end
            if (idx >= BUFFER_DEPTH || idx > frame_len + 1) begin
                end_with(ST_OVERRUN);
                return;
            end
            store[idx] = b;
            if (idx < frame_len)
                crc = crc_byte(crc, b);
            // high CRC byte closes the frame
            if (idx == frame_len + 1) begin
                crc_ok = (store[frame_len] == crc[7:0]) && (b == crc[15:8]);
                if (crc_ok) begin
                    for (i = 0; i <= frame_len; i++)
                        add_word(ST_BYTE, store[i], i, i == frame_len);
                    mode = MODE_HUNT;
                end else begin
                    add_word(ST_CRC_ERR, '0, 0, 1'b1);
                    mode = MODE_SWALLOW;
                end
                byte_count = 0;
                return;
            end
            byte_count = (idx + 1) & 63;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_word(t_result got);
            t_result want;
            string   diffs;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d byte=%02h idx=%0d last=%0d",
                    got.status, got.frame_byte, got.byte_index, got.last));
                return;
            end
            want  = expected_words.pop_front();
            diffs = "";
            if (got.status != want.status)
                diffs = {diffs, $sformatf(" status %0d exp %0d", got.status, want.status)};
            if (got.frame_byte != want.frame_byte)
                diffs = {diffs, $sformatf(" byte %02h exp %02h", got.frame_byte,
                    want.frame_byte)};
            if (got.byte_index != want.byte_index)
                diffs = {diffs, $sformatf(" idx %0d exp %0d", got.byte_index,
                    want.byte_index)};
            if (got.last != want.last)
                diffs = {diffs, $sformatf(" last %0d exp %0d", got.last, want.last)};
            if (diffs != "")
                report_mismatch({"word", diffs});
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [1:0]           o_status;
    logic [BYTE_W-1:0]    o_frame_byte;
    logic [IDX_W-1:0]     o_byte_index;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CRC_W-1:0]     i_cfg_data  = '0;

    frame_checker sb = new();

    bit hold_req    = 1'b0;
    bit no_gaps     = 1'b0;
    int burst_left  = 0;
    int frame_bytes = 0;

    sync_length_crc_deframer_top #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // cycle watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: check each popped word, stall on a rotating pattern
    initial begin : result_sink
        int      hold_left;
        int      rcv_cycle;
        int      style;
        t_result got;
        hold_left = 0;
        rcv_cycle = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.status     = t_status'(o_status);
                got.frame_byte = o_frame_byte;
                got.byte_index = o_byte_index;
                got.last       = o_last;
                sb.check_word(got);
            end
            rcv_cycle++;
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            style = (rcv_cycle / 97) % 4;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (style)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 1);
                    2: pop <= ((rcv_cycle % 5) < 2);
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // one rx word, sent in bursts with random gaps
    task automatic feed_rx_byte(logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0 && !no_gaps) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        sb.take_rx_byte(b);
    endtask

    // stop sending and wait until every expected word is out
    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no toggle
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CRC_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic load_config(logic [BYTE_W-1:0] sync_v, logic [CRC_W-1:0] poly_v,
                               logic [CRC_W-1:0] init_v);
        cfg_write(CFG_SYNC_BYTE, {8'h00, sync_v});
        cfg_write(CFG_CRC_POLY, poly_v);
        cfg_write(CFG_CRC_INIT, init_v);
        i_cfg_valid <= 1'b0;
    endtask

    // sync, length, payload, CRC low/high; fill < 0 gives random payload
    task automatic send_frame(int len, bit corrupt, int fill);
        logic [BYTE_W-1:0] fr [$];
        logic [CRC_W-1:0]  c;
        logic [BYTE_W-1:0] b;
        int                k;
        c = sb.init_val;
        fr.push_back(sb.sync_val);
        fr.push_back(len[7:0]);
        c = sb.crc_byte(c, len[7:0]);
        for (k = 2; k < len; k++) begin
            if (fill >= 0)
                b = fill[7:0];
            else if ($urandom_range(0, 9) == 0)
                b = sb.sync_val;
            else
                b = BYTE_W'($urandom_range(0, 255));
            fr.push_back(b);
            c = sb.crc_byte(c, b);
        end
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        if (corrupt) begin
            k = $urandom_range(2, fr.size() - 1);
            fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (fr[j]) feed_rx_byte(fr[j]);
        frame_bytes += fr.size();
    endtask

    task automatic send_noise();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == sb.sync_val);
        feed_rx_byte(b);
    endtask

    task automatic send_bad_length();
        logic [BYTE_W-1:0] lv;
        case ($urandom_range(0, 3))
            0: lv = 8'd0;
            1: lv = 8'd1;
            2: lv = 8'd31;
            default: lv = BYTE_W'($urandom_range(31, 255));
        endcase
        feed_rx_byte(sb.sync_val);
        feed_rx_byte(lv);
        frame_bytes += 2;
    endtask

    // frame cut short: the next sequence runs into it
    task automatic send_truncated();
        int len;
        int n;
        int k;
        len = $urandom_range(2, 8);
        n   = $urandom_range(1, len);
        feed_rx_byte(sb.sync_val);
        feed_rx_byte(len[7:0]);
        for (k = 0; k < n; k++) feed_rx_byte(BYTE_W'($urandom_range(0, 255)));
        frame_bytes += 2 + n;
    endtask

    task automatic random_sequence();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            if ($urandom_range(0, 99) < 8)
                send_frame(($urandom_range(0, 1) == 1) ? 30 : $urandom_range(9, 29), 1'b0, -1);
            else
                send_frame($urandom_range(2, 8), 1'b0, -1);
        end else if (r < 77) begin
            send_frame($urandom_range(2, 8), 1'b1, -1);
            // swallowed word, often the sync value
            feed_rx_byte(($urandom_range(0, 1) == 1) ? sb.sync_val
                                                     : BYTE_W'($urandom_range(0, 255)));
            frame_bytes++;
        end else if (r < 85) begin
            send_bad_length();
        end else if (r < 92) begin
            send_truncated();
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_noise();
        end
    endtask

    task automatic random_part();
        int start;
        start = frame_bytes;
        while (frame_bytes - start < PHASE_BYTES) random_sequence();
    endtask

    // field extremes, bad lengths, sync inside a frame, CRC error and swallow
    task automatic directed_part();
        feed_rx_byte(8'h00);
        feed_rx_byte(8'h7E);
        feed_rx_byte(sb.sync_val); feed_rx_byte(8'd0);
        feed_rx_byte(sb.sync_val); feed_rx_byte(8'd1);
        feed_rx_byte(sb.sync_val); feed_rx_byte(8'd31);
        feed_rx_byte(sb.sync_val); feed_rx_byte(8'd255);
        send_frame(2, 1'b0, -1);
        send_frame(3, 1'b0, 255);
        send_frame(2, 1'b1, -1);
        feed_rx_byte(sb.sync_val);
    endtask

    initial begin : stimulus
        int ph;
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: ;
                1: begin
                    cfg_write(CFG_UNUSED, CRC_W'($urandom_range(0, 65535)));
                    load_config(8'h00, 16'hFFFF, 16'h0000);
                end
                2: load_config(8'hA5, 16'h8408, 16'hFFFF);
                3: load_config(BYTE_W'($urandom_range(0, 255)),
                               CRC_W'($urandom_range(0, 65535)),
                               CRC_W'($urandom_range(0, 65535)));
                4: load_config(8'hFF, 16'h0000, CRC_W'($urandom_range(0, 65535)));
                default: load_config(8'h7E, CRC_POLY_RST, CRC_INIT_RST);
            endcase
            if (ph == 2)
                send_frame(30, 1'b0, -1);
            // receiver holds off while frames keep coming, so the input stalls
            if (ph == 3) begin
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                for (k = 0; k < 3; k++) send_frame($urandom_range(4, 10), 1'b0, -1);
                no_gaps  = 1'b0;
            end
            random_part();
        end
        settle();

        if (sb.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
